// ===== rtl/core/hsec_pkg.sv =====
// Shared widths, codes and helper functions for the Hamming SEC encoder/decoder.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package hsec_pkg;

    // Fixed field widths of the request and result beats and the data width register
    localparam int CODE_W       = 31;
    localparam int SYN_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int DATA_WIDTH_W = 5;

    // Largest value the data width register can hold
    localparam int DATA_WIDTH_MAX = (2 ** DATA_WIDTH_W) - 1;

    // Register reset value and default parameter value
    localparam logic [DATA_WIDTH_W-1:0] DATA_WIDTH_RESET = 5'd26;
    localparam int DEFAULT_MAX_DATA_BITS = 26;

    // Command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_CORRECTED     = 2'd1,
        ST_UNCORRECTABLE = 2'd2
    } hsec_status_t;

    // Smallest r with 2^r >= m + r + 1; the condition fails for a prefix of r,
    // so counting the r values where it fails gives the answer.
    function automatic int parity_count(input int m);
        int cnt;
        cnt = 0;
        for (int r = 0; r < 8; r++) begin
            if ((1 << r) < (m + r + 1)) begin
                cnt++;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsec_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on hsec_pkg for the field widths.
`default_nettype none

interface hsec_in_if
    import hsec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [CODE_W-1:0]   word;

    modport source (output valid, output command, output word, input ready);
    modport sink   (input valid, input command, input word, output ready);
endinterface

interface hsec_out_if
    import hsec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   code_out;
    logic [SYN_W-1:0]    syndrome;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output code_out, output syndrome, output status,
                    input ready);
    modport sink   (input valid, input code_out, input syndrome, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsec_syn_tree.sv =====
// Syndrome XOR trees: bit k is the parity of all code positions whose index has bit k set.
// Depends on hsec_pkg for the default code width; purely combinational.
`default_nettype none

module hsec_syn_tree
    import hsec_pkg::*;
#(
    parameter int CODE_BITS = DEFAULT_MAX_DATA_BITS + 5,
    parameter int SYN_BITS  = 5
)(
    input  logic [CODE_BITS-1:0] code,
    output logic [SYN_BITS-1:0]  syn
);

    // Coverage mask of syndrome bit k over positions 1..CODE_BITS
    function automatic logic [CODE_BITS-1:0] cover_mask(input int k);
        logic [CODE_BITS-1:0] mask;
        mask = '0;
        for (int p = 0; p < CODE_BITS; p++) begin
            mask[p] = (((p + 1) >> k) & 1) != 0;
        end
        return mask;
    endfunction

    // Reduce each covered set
    for (genvar k = 0; k < SYN_BITS; k++) begin : g_bit
        localparam logic [CODE_BITS-1:0] MASK = cover_mask(k);
        assign syn[k] = ^(code & MASK);
    end

endmodule

`default_nettype wire

// ===== rtl/core/hamming_sec_encode_decode_unit.sv =====
// Hamming SEC encoder/decoder, three register stages: place/mask, syndrome, correct.
// Throughput one beat per cycle while the result side accepts beats.
// Stalls come back from the result side and an empty stage still advances; the syndrome XOR tree sets stage depth.
// Reset clears all stage valid bits and loads the data width register with 26.
// Depends on hsec_pkg, hsec_if and hsec_syn_tree.
`default_nettype none

module hamming_sec_encode_decode_unit
    import hsec_pkg::*;
#(
    parameter int MAX_DATA_BITS = DEFAULT_MAX_DATA_BITS
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [DATA_WIDTH_W-1:0] cfg_wr_data,
    hsec_in_if.sink                 request,
    hsec_out_if.source              result
);

    // Code geometry at the widest data width the register can select
    localparam int M_CAP  = (MAX_DATA_BITS < DATA_WIDTH_MAX) ? MAX_DATA_BITS : DATA_WIDTH_MAX;
    localparam int R_MAX  = parity_count(M_CAP);
    localparam int N_MAX  = M_CAP + R_MAX;
    localparam int N_W    = $clog2(N_MAX + 1);
    localparam int SYN_IW = R_MAX;
    localparam int CMP_W  = N_W + SYN_IW;

    logic [DATA_WIDTH_W-1:0] data_width_reg;

    logic [N_W-1:0]   m_eff;
    logic [N_W-1:0]   r_cur;
    logic [N_W-1:0]   n_cur;
    logic [N_MAX-1:0] n_mask;
    logic [N_MAX-1:0] word_ext;
    logic [N_MAX-1:0] scatter;

    logic adv1;
    logic adv2;
    logic adv3;

    logic             v1_reg;
    logic             cmd1_reg;
    logic [N_MAX-1:0] code1_reg;
    logic [N_MAX-1:0] code1_next;

    logic              v2_reg;
    logic              cmd2_reg;
    logic [N_MAX-1:0]  code2_reg;
    logic [SYN_IW-1:0] syn2_reg;
    logic [SYN_IW-1:0] syn2_next;

    logic              v3_reg;
    logic [N_MAX-1:0]  code3_reg;
    logic [N_MAX-1:0]  code3_next;
    logic [SYN_IW-1:0] syn3_reg;
    logic [SYN_IW-1:0] syn3_next;
    hsec_status_t      status3_reg;
    hsec_status_t      status3_next;

    logic [N_MAX-1:0] flip_vec;
    logic [N_MAX-1:0] par_vec;

    // Hold the data width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_width_reg <= DATA_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            data_width_reg <= cfg_wr_data;
        end
    end

    // Clamp the width and derive parity count and code length
    always_comb
    begin
        if (data_width_reg == '0)
        begin
            m_eff = N_W'(1);
        end
        else if (int'(data_width_reg) > M_CAP)
        begin
            m_eff = N_W'(M_CAP);
        end
        else
        begin
            m_eff = N_W'(data_width_reg);
        end
        r_cur = N_W'(parity_count(int'(m_eff)));
        n_cur = m_eff + r_cur;
    end

    // Keep positions 1..n only
    always_comb
    begin
        for (int p = 0; p < N_MAX; p++)
        begin
            n_mask[p] = p < int'(n_cur);
        end
    end

    // Stall control: a stage advances when it is empty or the next one advances
    assign adv3          = !v3_reg || result.ready;
    assign adv2          = !v2_reg || adv3;
    assign adv1          = !v1_reg || adv2;
    assign request.ready = adv1;

    // Stage 1: widen the received word and scatter data bits to non-power-of-two positions
    for (genvar p = 0; p < N_MAX; p++)
    begin : g_word
        if (p < CODE_W)
        begin : g_in
            assign word_ext[p] = request.word[p];
        end
        else
        begin : g_pad
            assign word_ext[p] = 1'b0;
        end
    end

    for (genvar p = 1; p <= N_MAX; p++)
    begin : g_scatter
        if ((p & (p - 1)) == 0)
        begin : g_par
            assign scatter[p-1] = 1'b0;
        end
        else
        begin : g_dat
            localparam int K = (p - 1) - $clog2(p);
            if (K < CODE_W)
            begin : g_bit
                assign scatter[p-1] = request.word[K];
            end
            else
            begin : g_zero
                assign scatter[p-1] = 1'b0;
            end
        end
    end

    assign code1_next = ((request.command == CMD_ENCODE) ? scatter : word_ext) & n_mask;

    // Stage 2: syndrome over the masked code word
    hsec_syn_tree #(
        .CODE_BITS (N_MAX),
        .SYN_BITS  (SYN_IW)
    ) u_syn_tree (
        .code (code1_reg),
        .syn  (syn2_next)
    );

    // Stage 3: insert parity on encode, correct or flag on decode
    for (genvar p = 0; p < N_MAX; p++)
    begin : g_fix
        assign flip_vec[p] = syn2_reg == SYN_IW'(p + 1);
        if (((p + 1) & p) == 0)
        begin : g_par
            assign par_vec[p] = syn2_reg[$clog2(p + 1)];
        end
        else
        begin : g_dat
            assign par_vec[p] = 1'b0;
        end
    end

    always_comb
    begin
        code3_next   = code2_reg;
        syn3_next    = '0;
        status3_next = ST_OK;
        if (cmd2_reg == CMD_ENCODE)
        begin
            code3_next = code2_reg | par_vec;
        end
        else
        begin
            syn3_next = syn2_reg;
            if (syn2_reg == '0)
            begin
                status3_next = ST_OK;
            end
            else if (CMP_W'(syn2_reg) <= CMP_W'(n_cur))
            begin
                code3_next   = code2_reg ^ flip_vec;
                status3_next = ST_CORRECTED;
            end
            else
            begin
                status3_next = ST_UNCORRECTABLE;
            end
        end
    end

    // Advance the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= request.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Advance the stage payloads; hold them while stalled
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cmd1_reg  <= request.command;
            code1_reg <= code1_next;
        end
        if (adv2)
        begin
            cmd2_reg  <= cmd1_reg;
            code2_reg <= code1_reg;
            syn2_reg  <= syn2_next;
        end
        if (adv3)
        begin
            code3_reg   <= code3_next;
            syn3_reg    <= syn3_next;
            status3_reg <= status3_next;
        end
    end

    // Drive the result beat
    for (genvar i = 0; i < CODE_W; i++)
    begin : g_out
        if (i < N_MAX)
        begin : g_bit
            assign result.code_out[i] = code3_reg[i];
        end
        else
        begin : g_pad
            assign result.code_out[i] = 1'b0;
        end
    end

    assign result.valid    = v3_reg;
    assign result.syndrome = SYN_W'(syn3_reg);
    assign result.status   = status3_reg;

    // A corrected word always comes with a nonzero syndrome
    a_corr_syn: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && status3_reg == ST_CORRECTED |-> syn3_reg != '0)
        else $error("corrected result carries zero syndrome");

    // Positions beyond the code length stay clear
    a_len_mask: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (code3_reg & ~n_mask) == '0)
        else $error("result has bits beyond code length");

    // A stalled middle stage keeps its beat
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !adv2 |=> v2_reg && $stable(code2_reg) && $stable(syn2_reg))
        else $error("stalled syndrome stage lost its beat");

    // An accepted request lands in the first stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> v1_reg)
        else $error("accepted request did not enter the pipeline");

endmodule

`default_nettype wire

// ===== dv/hamming_sec_encode_decode_unit_tb.sv =====
// Self-checking testbench for the Hamming SEC encode/decode unit.
// Depends on hsec_pkg and the hsec_in_if / hsec_out_if channel interfaces.
// Runs a directed table, then random phases over several data widths, with random idling.

module hamming_sec_encode_decode_unit_tb;
    import hsec_pkg::*;

    localparam int DATA_BITS_CAP  = DEFAULT_MAX_DATA_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_ITEMS    = 65;

    // One result beat
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SYN_W-1:0]  syn;
        hsec_status_t      st;
    } hamming_res_t;

    // One row of the directed table
    typedef struct {
        logic [DATA_WIDTH_W-1:0] width;
        logic                    cmd;
        logic [CODE_W-1:0]       word;
        bit                      typed;
        hamming_res_t            res;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                    cfg_wr_en   = 1'b0;
    logic [DATA_WIDTH_W-1:0] cfg_wr_data = '0;

    logic              req_valid = 1'b0;
    logic              req_cmd   = CMD_ENCODE;
    logic [CODE_W-1:0] req_word  = '0;
    logic              sink_ready = 1'b0;

    // Typed expectation travels with the beat it belongs to
    bit           beat_typed     = 1'b0;
    hamming_res_t beat_typed_res = '0;

    logic [DATA_WIDTH_W-1:0] width_shadow = DATA_WIDTH_RESET;
    int unsigned idle_pct  = 32;
    int unsigned stall_pct = 32;

    hamming_res_t pending_q[$];
    int unsigned  mismatch_count = 0;
    int unsigned  idle_cycles    = 0;

    hsec_in_if  req_if();
    hsec_out_if res_if();

    assign req_if.valid   = req_valid;
    assign req_if.command = req_cmd;
    assign req_if.word    = req_word;
    assign res_if.ready   = sink_ready;

    hamming_sec_encode_decode_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_if),
        .result      (res_if)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamp the register value to the usable data width
    function automatic int eff_data_bits(input logic [DATA_WIDTH_W-1:0] width_reg);
        int m;
        m = width_reg;
        if (m < 1)
            m = 1;
        if (m > DATA_BITS_CAP)
            m = DATA_BITS_CAP;
        return m;
    endfunction

    function automatic int code_length(input logic [DATA_WIDTH_W-1:0] width_reg);
        int m;
        int r;
        m = eff_data_bits(width_reg);
        r = 0;
        while ((1 << r) < (m + r + 1))
            r++;
        return m + r;
    endfunction

    // XOR of the indices of all set positions 1..n
    function automatic logic [SYN_W-1:0] code_syndrome(input logic [CODE_W-1:0] code,
                                                       input int n);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int pos = 1; pos <= n; pos++)
            if (code[pos-1])
                s ^= pos[SYN_W-1:0];
        return s;
    endfunction

    function automatic hamming_res_t hamming_predict(input logic cmd,
                                                     input logic [CODE_W-1:0] word,
                                                     input logic [DATA_WIDTH_W-1:0] width_reg);
        hamming_res_t     res;
        int               m;
        int               n;
        int               k;
        logic [SYN_W-1:0] s;
        logic [CODE_W-1:0] nmask;
        m     = eff_data_bits(width_reg);
        n     = code_length(width_reg);
        nmask = (n >= CODE_W) ? '1 : ((31'd1 << n) - 31'd1);
        res   = '{code: '0, syn: '0, st: ST_OK};
        if (cmd == CMD_ENCODE) begin
            // place data bits at the non-power-of-two positions
            k = 0;
            for (int pos = 1; pos <= n; pos++) begin
                if ((pos & (pos - 1)) != 0) begin
                    res.code[pos-1] = word[k];
                    k++;
                end
            end
            // set parity bits so every check group is even
            s = code_syndrome(res.code, n);
            for (int i = 0; i < n - m; i++)
                if (s[i])
                    res.code[(1 << i) - 1] = 1'b1;
        end else begin
            res.code = word & nmask;
            res.syn  = code_syndrome(res.code, n);
            if (res.syn == '0) begin
                res.st = ST_OK;
            end else if (int'(res.syn) <= n) begin
                res.code[res.syn-1] = ~res.code[res.syn-1];
                res.st = ST_CORRECTED;
            end else begin
                res.st = ST_UNCORRECTABLE;
            end
        end
        return res;
    endfunction

    // Random output-side backpressure
    always @(posedge clk)
        sink_ready <= ($urandom_range(99) >= stall_pct);

    // Predict on request beats, check result beats in order
    always @(posedge clk) begin : scoreboard
        hamming_res_t want;
        if (rst_n) begin
            if (req_valid && req_if.ready) begin
                if (beat_typed)
                    pending_q.push_back(beat_typed_res);
                else
                    pending_q.push_back(hamming_predict(req_cmd, req_word, width_shadow));
            end
            if (res_if.valid && sink_ready) begin
                if (pending_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result beat: code=%h syn=%0d st=%0d",
                                 res_if.code_out, res_if.syndrome, res_if.status);
                end else begin
                    want = pending_q.pop_front();
                    if (res_if.code_out !== want.code || res_if.syndrome !== want.syn ||
                        res_if.status !== want.st) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: exp code=%h syn=%0d st=%0d, ",
                                      "got code=%h syn=%0d st=%0d"},
                                     want.code, want.syn, want.st,
                                     res_if.code_out, res_if.syndrome, res_if.status);
                    end
                end
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_if.ready) || (res_if.valid && sink_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL hamming_sec_encode_decode_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request beat, with random idle cycles first; return at acceptance
    task automatic send_beat(input logic cmd, input logic [CODE_W-1:0] word,
                             input bit typed, input hamming_res_t typed_res);
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_cmd        <= cmd;
        req_word       <= word;
        beat_typed     <= typed;
        beat_typed_res <= typed_res;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [DATA_WIDTH_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        width_shadow  = value;
        @(posedge clk);
    endtask

    // Directed table; typed results only where obvious
    stim_row_t dir_rows[24] = '{
        '{5'd26, CMD_ENCODE, 31'h0000_0000, 1'b1, '{31'h0000_0000, 5'd0,  ST_OK}},
        '{5'd26, CMD_DECODE, 31'h0000_0000, 1'b1, '{31'h0000_0000, 5'd0,  ST_OK}},
        '{5'd26, CMD_ENCODE, 31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 5'd0,  ST_OK}},
        '{5'd26, CMD_DECODE, 31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 5'd0,  ST_OK}},
        '{5'd26, CMD_DECODE, 31'h0000_0001, 1'b1, '{31'h0000_0000, 5'd1,  ST_CORRECTED}},
        '{5'd26, CMD_DECODE, 31'h4000_0000, 1'b1, '{31'h0000_0000, 5'd31, ST_CORRECTED}},
        '{5'd26, CMD_ENCODE, 31'h0000_0001, 1'b0, '{'0, '0, ST_OK}},
        '{5'd26, CMD_ENCODE, 31'h02AA_AAAA, 1'b0, '{'0, '0, ST_OK}},
        '{5'd26, CMD_DECODE, 31'h5555_5555, 1'b0, '{'0, '0, ST_OK}},
        // width zero behaves as one data bit
        '{5'd0,  CMD_ENCODE, 31'h0000_0001, 1'b0, '{'0, '0, ST_OK}},
        '{5'd0,  CMD_ENCODE, 31'h7FFF_FFFE, 1'b1, '{31'h0000_0000, 5'd0,  ST_OK}},
        '{5'd0,  CMD_DECODE, 31'h7FFF_FFF8, 1'b1, '{31'h0000_0000, 5'd0,  ST_OK}},
        '{5'd0,  CMD_DECODE, 31'h0000_0001, 1'b1, '{31'h0000_0000, 5'd1,  ST_CORRECTED}},
        // n = 5: syndrome 6 lies beyond the code
        '{5'd2,  CMD_DECODE, 31'h0000_000A, 1'b1, '{31'h0000_000A, 5'd6,  ST_UNCORRECTABLE}},
        '{5'd2,  CMD_DECODE, 31'h7FFF_FFF7, 1'b0, '{'0, '0, ST_OK}},
        '{5'd2,  CMD_ENCODE, 31'h0000_0003, 1'b0, '{'0, '0, ST_OK}},
        // widths above the cap clamp to 26
        '{5'd31, CMD_ENCODE, 31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 5'd0,  ST_OK}},
        '{5'd31, CMD_DECODE, 31'h0000_0002, 1'b0, '{'0, '0, ST_OK}},
        '{5'd27, CMD_DECODE, 31'h0000_0003, 1'b0, '{'0, '0, ST_OK}},
        '{5'd1,  CMD_ENCODE, 31'h0000_0000, 1'b1, '{31'h0000_0000, 5'd0,  ST_OK}},
        '{5'd1,  CMD_ENCODE, 31'h0000_0001, 1'b0, '{'0, '0, ST_OK}},
        '{5'd4,  CMD_DECODE, 31'h0000_007F, 1'b0, '{'0, '0, ST_OK}},
        '{5'd11, CMD_ENCODE, 31'h0000_07FF, 1'b0, '{'0, '0, ST_OK}},
        '{5'd11, CMD_DECODE, 31'h7FFF_FFFF, 1'b0, '{'0, '0, ST_OK}}
    };

    logic [DATA_WIDTH_W-1:0] phase_widths[10] = '{
        5'd26, 5'd1, 5'd31, 5'd0, 5'd2, 5'd4, 5'd11, 5'd27, 5'd0, 5'd0
    };

    initial begin : stimulus
        logic [DATA_WIDTH_W-1:0] w;
        logic [CODE_W-1:0]       word;
        logic [CODE_W-1:0]       nmask;
        hamming_res_t            enc;
        int unsigned             pick;
        int                      n;
        int                      p1;
        int                      p2;

        // hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table; first rows run on the reset width
        foreach (dir_rows[i]) begin
            if (dir_rows[i].width != width_shadow)
                write_width(dir_rows[i].width);
            send_beat(dir_rows[i].cmd, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
        end

        // random phases, one width each
        foreach (phase_widths[ph]) begin
            w = (ph >= 8) ? 5'($urandom_range(31)) : phase_widths[ph];
            write_width(w);
            // one phase without any idling on either side
            idle_pct  = (ph == 5) ? 0 : 32;
            stall_pct = (ph == 5) ? 0 : 32;
            n     = code_length(w);
            nmask = (n >= CODE_W) ? '1 : ((31'd1 << n) - 31'd1);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                pick = $urandom_range(99);
                word = 31'($urandom);
                if (pick < 30) begin
                    send_beat(CMD_ENCODE, word, 1'b0, '0);
                end else if (pick >= 85) begin
                    send_beat(CMD_DECODE, word, 1'b0, '0);
                end else begin
                    // well-formed code word, then flip zero, one or two positions
                    enc  = hamming_predict(CMD_ENCODE, word, w);
                    word = enc.code;
                    p1 = $urandom_range(n, 1);
                    p2 = $urandom_range(n - 1, 1);
                    if (p2 >= p1)
                        p2++;
                    if (pick >= 50)
                        word[p1-1] = ~word[p1-1];
                    if (pick >= 75)
                        word[p2-1] = ~word[p2-1];
                    // junk above the code length now and then
                    if ($urandom_range(3) == 0)
                        word |= 31'($urandom) & ~nmask;
                    send_beat(CMD_DECODE, word, 1'b0, '0);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_q.size() == 0) begin
            $display("PASS hamming_sec_encode_decode_unit");
        end else begin
            $display("FAIL hamming_sec_encode_decode_unit");
        end
        $finish;
    end

endmodule
